// ===== rtl/drive_enable_interlock_defines.svh =====
`ifndef DRIVE_ENABLE_INTERLOCK_DEFINES_SVH
`define DRIVE_ENABLE_INTERLOCK_DEFINES_SVH

// same-cycle implication under reset
`define DEI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interlock check failed");

// next-cycle implication under reset
`define DEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interlock check failed");

`endif

// ===== rtl/dei_pkg.sv =====
package dei_pkg;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int STICK_COUNT = 4;
    localparam int TILT_COUNT  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STARTUP_TICKS    = 3'd0,
        REG_HOLD_TICKS       = 3'd1,
        REG_STICK_IDLE_TICKS = 3'd2,
        REG_AWAY_TICKS       = 3'd3,
        REG_TILT_NOISE_BAND  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] startup_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] stick_idle_ticks;
        logic [7:0] away_ticks;
        logic [6:0] tilt_noise_band;
    } cfg_t;

    localparam logic [7:0] RST_STARTUP_TICKS    = 8'd150;
    localparam logic [7:0] RST_HOLD_TICKS       = 8'd50;
    localparam logic [7:0] RST_STICK_IDLE_TICKS = 8'd50;
    localparam logic [7:0] RST_AWAY_TICKS       = 8'd100;
    localparam logic [6:0] RST_TILT_NOISE_BAND  = 7'd1;

endpackage

// ===== rtl/dei_cfg_regs.sv =====
module dei_cfg_regs
    import dei_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_STARTUP_TICKS:    cfg_next.startup_ticks    = cfg_wdata;
                REG_HOLD_TICKS:       cfg_next.hold_ticks       = cfg_wdata;
                REG_STICK_IDLE_TICKS: cfg_next.stick_idle_ticks = cfg_wdata;
                REG_AWAY_TICKS:       cfg_next.away_ticks       = cfg_wdata;
                REG_TILT_NOISE_BAND:  cfg_next.tilt_noise_band  = cfg_wdata[6:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_ticks    <= RST_STARTUP_TICKS;
            cfg_reg.hold_ticks       <= RST_HOLD_TICKS;
            cfg_reg.stick_idle_ticks <= RST_STICK_IDLE_TICKS;
            cfg_reg.away_ticks       <= RST_AWAY_TICKS;
            cfg_reg.tilt_noise_band  <= RST_TILT_NOISE_BAND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dei_in_stage.sv =====
module dei_in_stage
    import dei_pkg::*;
#(
    parameter int DATA_W = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_data,
    input  logic              s_flag,
    input  logic              fire,
    output logic              valid,
    output logic [DATA_W-1:0] data,
    output logic              flag
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic              flag_reg;
    logic              take;

    assign s_tready = !valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= s_data;
            flag_reg <= s_flag;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign flag  = flag_reg;

endmodule

// ===== rtl/dei_core.sv =====
`include "drive_enable_interlock_defines.svh"

module dei_core
    import dei_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int COUNT_BITS  = 8
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cfg_t                                     cfg,
    input  logic                                     fire,
    input  logic [STICK_COUNT-1:0][SAMPLE_BITS-1:0]  sticks,
    input  logic [TILT_COUNT-1:0][SAMPLE_BITS-1:0]   tilt,
    input  logic                                     switch_down,
    output logic                                     res_system,
    output logic                                     res_drive
);

    localparam int HW = COUNT_BITS + 1;
    localparam int CW = (HW > 8) ? HW : 8;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int MW = (DW > 7) ? DW : 7;
    localparam logic [COUNT_BITS-1:0] IDLE_MAX = {COUNT_BITS{1'b1}};
    localparam logic [HW-1:0]         WIDE_MAX = {HW{1'b1}};

    logic [STICK_COUNT-1:0][SAMPLE_BITS-1:0] prev_sticks_reg;
    logic [TILT_COUNT-1:0][SAMPLE_BITS-1:0]  prev_tilt_reg, prev_tilt_next;
    logic [7:0]            startup_count_reg, startup_count_next;
    logic                  switch_latch_reg, switch_latch_next;
    logic [HW-1:0]         hold_count_reg, hold_count_next;
    logic [COUNT_BITS-1:0] idle_count_reg, idle_count_next;
    logic [HW-1:0]         away_count_reg, away_count_next;
    logic                  system_flag_reg, system_flag_next;
    logic                  drive_flag_reg, drive_flag_next;

    logic                  moved;
    logic                  idle;
    logic [8:0]            startup_inc;
    logic                  in_startup;
    logic signed [DW-1:0]  diff [TILT_COUNT];
    logic [DW-1:0]         mag [TILT_COUNT];
    logic [TILT_COUNT-1:0] still;
    logic                  tilted;

    always_comb
    begin
        moved = 1'b0;
        for (int i = 0; i < STICK_COUNT; i++)
        begin
            if (sticks[i] != prev_sticks_reg[i])
            begin
                moved = 1'b1;
            end
        end
    end

    // tilt change with the noise band taken out
    always_comb
    begin
        tilted = 1'b0;
        for (int i = 0; i < TILT_COUNT; i++)
        begin
            diff[i] = $signed({tilt[i][SAMPLE_BITS-1], tilt[i]})
                    - $signed({prev_tilt_reg[i][SAMPLE_BITS-1], prev_tilt_reg[i]});
            mag[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
            still[i] = MW'(mag[i]) <= MW'(cfg.tilt_noise_band);
            if (tilt[i] != '0)
            begin
                tilted = 1'b1;
            end
        end
    end

    assign startup_inc = {1'b0, startup_count_reg} + 9'd1;
    assign in_startup  = startup_inc <= {1'b0, cfg.startup_ticks};

    always_comb
    begin
        prev_tilt_next     = prev_tilt_reg;
        startup_count_next = startup_count_reg;
        switch_latch_next  = switch_latch_reg;
        hold_count_next    = hold_count_reg;
        idle_count_next    = idle_count_reg;
        away_count_next    = away_count_reg;
        system_flag_next   = system_flag_reg;
        drive_flag_next    = drive_flag_reg;
        idle               = 1'b0;

        if (in_startup)
        begin
            startup_count_next = startup_inc[7:0];
            if (switch_down)
            begin
                switch_latch_next = 1'b1;
            end
        end
        else
        begin
            startup_count_next = cfg.startup_ticks;
            if (switch_latch_reg)
            begin
                system_flag_next = 1'b0;
                drive_flag_next  = 1'b0;
                if (!switch_down)
                begin
                    switch_latch_next = 1'b0;
                end
            end
            else
            begin
                system_flag_next = 1'b1;

                if (!moved)
                begin
                    if (CW'(idle_count_reg) >= CW'(cfg.stick_idle_ticks))
                    begin
                        idle = 1'b1;
                    end
                    else if (idle_count_reg < IDLE_MAX)
                    begin
                        idle_count_next = idle_count_reg + 1'b1;
                    end
                end
                else
                begin
                    idle_count_next = '0;
                end

                away_count_next = '0;
                if (drive_flag_reg && idle)
                begin
                    prev_tilt_next = tilt;
                    if ((&still) && tilted)
                    begin
                        away_count_next = (away_count_reg < WIDE_MAX)
                                        ? away_count_reg + 1'b1 : away_count_reg;
                    end
                end

                if (CW'(away_count_next) >= CW'(cfg.away_ticks))
                begin
                    // forced shutdown
                    drive_flag_next   = 1'b0;
                    system_flag_next  = 1'b0;
                    switch_latch_next = 1'b1;
                    hold_count_next   = '0;
                    away_count_next   = '0;
                end
                else
                begin
                    hold_count_next = hold_count_reg;
                    if (CW'(hold_count_reg) >= CW'(cfg.hold_ticks))
                    begin
                        drive_flag_next = 1'b1;
                        hold_count_next = HW'(cfg.hold_ticks);
                    end
                    if (switch_down)
                    begin
                        if (hold_count_next < WIDE_MAX)
                        begin
                            hold_count_next = hold_count_next + 1'b1;
                        end
                    end
                    else
                    begin
                        drive_flag_next = 1'b0;
                        hold_count_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sticks_reg   <= '0;
            prev_tilt_reg     <= '0;
            startup_count_reg <= '0;
            switch_latch_reg  <= 1'b0;
            hold_count_reg    <= '0;
            idle_count_reg    <= '0;
            away_count_reg    <= '0;
            system_flag_reg   <= 1'b0;
            drive_flag_reg    <= 1'b0;
        end
        else if (fire)
        begin
            prev_sticks_reg   <= sticks;
            prev_tilt_reg     <= prev_tilt_next;
            startup_count_reg <= startup_count_next;
            switch_latch_reg  <= switch_latch_next;
            hold_count_reg    <= hold_count_next;
            idle_count_reg    <= idle_count_next;
            away_count_reg    <= away_count_next;
            system_flag_reg   <= system_flag_next;
            drive_flag_reg    <= drive_flag_next;
        end
    end

    assign res_system = system_flag_next;
    assign res_drive  = drive_flag_next;

    `DEI_ASSERT_NOW(a_drive_needs_system, clk, rst_n, drive_flag_reg, system_flag_reg)
    `DEI_ASSERT_NOW(a_latch_forces_off, clk, rst_n,
        fire && !in_startup && switch_latch_reg, !res_system && !res_drive)
    `DEI_ASSERT_NEXT(a_release_stops_drive, clk, rst_n,
        fire && !in_startup && !switch_down, !drive_flag_reg)

endmodule

// ===== rtl/dei_out_stage.sv =====
module dei_out_stage
    import dei_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       res_system,
    input  logic       res_drive,
    output logic       out_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] data_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= {res_drive, res_system};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, data_reg};

endmodule

// ===== rtl/drive_enable_interlock.sv =====
// Safety interlock for a remote-controlled robot, one control tick per stream transfer.
// A new input is taken every clock cycle unless the result side stalls; each tick passes
// through the input register, then the result register, and its state update is a single
// pass of compare and increment logic between them. Outputs stay held for startup_ticks
// ticks after reset, a switch found down during that window or a forced shutdown latches
// both enables off until the switch is released, and drive enables once the switch has been
// held for hold_ticks ticks. Config writes are expected only while no tick is in flight.
module drive_enable_interlock
    import dei_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int COUNT_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // right_stick_y, right_stick_x, left_stick_y, left_stick_x, tilt_x, tilt_y
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // switch_down
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // system_enable, drive_enable
    output logic [7:0]            m_tdata
);

    localparam int FIELD_W = 6 * SAMPLE_BITS;

    cfg_t                cfg;
    logic                fire;
    logic                out_ready;
    logic                in_valid;
    logic [FIELD_W-1:0]  in_data;
    logic                in_switch;
    logic                res_system;
    logic                res_drive;
    logic [STICK_COUNT-1:0][SAMPLE_BITS-1:0] sticks;
    logic [TILT_COUNT-1:0][SAMPLE_BITS-1:0]  tilt;

    dei_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dei_in_stage #(
        .DATA_W (FIELD_W)
    ) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata[FIELD_W-1:0]),
        .s_flag   (s_tuser),
        .fire     (fire),
        .valid    (in_valid),
        .data     (in_data),
        .flag     (in_switch)
    );

    assign fire   = in_valid && out_ready;
    assign sticks = in_data[STICK_COUNT*SAMPLE_BITS-1:0];
    assign tilt   = in_data[FIELD_W-1:STICK_COUNT*SAMPLE_BITS];

    dei_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .sticks      (sticks),
        .tilt        (tilt),
        .switch_down (in_switch),
        .res_system  (res_system),
        .res_drive   (res_drive)
    );

    dei_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .res_system (res_system),
        .res_drive  (res_drive),
        .out_ready  (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    import dei_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 9;

    // packed so that the lower 48 bits match s_tdata
    typedef struct packed {
        logic              sw;
        logic signed [7:0] tilt_y;
        logic signed [7:0] tilt_x;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
    } tick_t;

    typedef struct packed {
        logic drive_enable;
        logic system_enable;
    } result_t;

    typedef struct {
        logic       is_cfg;
        cfg_index_t idx;
        logic [7:0] val;
        tick_t      t;
        logic       typed;
        result_t    want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    // right_stick_y, right_stick_x, left_stick_y, left_stick_x, tilt_x, tilt_y
    logic [47:0] s_tdata;
    // switch_down
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // system_enable, drive_enable
    logic [7:0]  m_tdata;

    drive_enable_interlock u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // interlock predictor state
    cfg_t              regs;
    logic [7:0]        last_stick [4];
    logic signed [7:0] last_tilt [2];
    logic [7:0]        startup_cnt;
    logic [7:0]        idle_cnt;
    logic [8:0]        hold_cnt;
    logic [8:0]        away_cnt;
    logic              latched;
    logic              sys_on;
    logic              drv_on;

    result_t   enable_q [$];
    plan_row_t plan [$];
    cfg_t      phase_cfg [PHASES];
    int        phase_len [PHASES];

    int errors;
    int ticks_sent;
    int results_seen;
    int reg_writes;
    int shutdowns;
    int drive_ticks;
    int stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    always #6 clk = ~clk;

    function automatic void interlock_reset();
        regs.startup_ticks    = RST_STARTUP_TICKS;
        regs.hold_ticks       = RST_HOLD_TICKS;
        regs.stick_idle_ticks = RST_STICK_IDLE_TICKS;
        regs.away_ticks       = RST_AWAY_TICKS;
        regs.tilt_noise_band  = RST_TILT_NOISE_BAND;
        foreach (last_stick[i]) last_stick[i] = '0;
        foreach (last_tilt[i]) last_tilt[i] = '0;
        startup_cnt = '0;
        idle_cnt    = '0;
        hold_cnt    = '0;
        away_cnt    = '0;
        latched     = 1'b0;
        sys_on      = 1'b0;
        drv_on      = 1'b0;
    endfunction

    // tilt change inside the noise band counts as no change
    function automatic logic signed [8:0] squelch(input logic signed [8:0] d);
        logic signed [8:0] mag;
        mag = (d < 0) ? -d : d;
        return (mag <= $signed({2'b00, regs.tilt_noise_band})) ? 9'sd0 : d;
    endfunction

    function automatic result_t interlock_tick(input tick_t t);
        logic [7:0]        cur [4];
        logic              moved;
        logic              idle;
        logic signed [8:0] cx;
        logic signed [8:0] cy;
        logic signed [8:0] px;
        logic signed [8:0] py;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        result_t           r;
        cur[0] = t.right_y;
        cur[1] = t.right_x;
        cur[2] = t.left_y;
        cur[3] = t.left_x;
        moved = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (cur[i] != last_stick[i]) moved = 1'b1;
            last_stick[i] = cur[i];
        end
        if ({1'b0, startup_cnt} + 9'd1 <= {1'b0, regs.startup_ticks})
        begin
            startup_cnt = startup_cnt + 8'd1;
            if (t.sw) latched = 1'b1;
        end
        else
        begin
            startup_cnt = regs.startup_ticks;
            if (latched)
            begin
                sys_on = 1'b0;
                drv_on = 1'b0;
                if (!t.sw) latched = 1'b0;
            end
            else
            begin
                sys_on = 1'b1;
                idle = 1'b0;
                if (!moved)
                begin
                    if (idle_cnt >= regs.stick_idle_ticks) idle = 1'b1;
                    else if (idle_cnt != 8'hff) idle_cnt = idle_cnt + 8'd1;
                end
                else
                    idle_cnt = '0;
                if (drv_on && idle)
                begin
                    cx = t.tilt_x;
                    cy = t.tilt_y;
                    px = last_tilt[0];
                    py = last_tilt[1];
                    dx = squelch(cx - px);
                    dy = squelch(cy - py);
                    last_tilt[0] = t.tilt_x;
                    last_tilt[1] = t.tilt_y;
                    if (dx == 0 && dy == 0 && (cx != 0 || cy != 0))
                    begin
                        if (away_cnt != 9'h1ff) away_cnt = away_cnt + 9'd1;
                    end
                    else
                        away_cnt = '0;
                end
                else
                    away_cnt = '0;
                if (away_cnt >= {1'b0, regs.away_ticks})
                begin
                    // operator walked away: full shutdown, latch until release
                    sys_on   = 1'b0;
                    drv_on   = 1'b0;
                    latched  = 1'b1;
                    hold_cnt = '0;
                    away_cnt = '0;
                    shutdowns++;
                end
                else
                begin
                    if (hold_cnt >= {1'b0, regs.hold_ticks})
                    begin
                        drv_on   = 1'b1;
                        hold_cnt = {1'b0, regs.hold_ticks};
                    end
                    if (t.sw)
                    begin
                        if (hold_cnt != 9'h1ff) hold_cnt = hold_cnt + 9'd1;
                    end
                    else
                    begin
                        drv_on   = 1'b0;
                        hold_cnt = '0;
                    end
                end
            end
        end
        if (drv_on) drive_ticks++;
        r.system_enable = sys_on;
        r.drive_enable  = drv_on;
        return r;
    endfunction

    function automatic tick_t tk(input logic [7:0] ry, rx, ly, lx, tx, ty, input logic sw);
        tick_t t;
        t.right_y = ry;
        t.right_x = rx;
        t.left_y  = ly;
        t.left_x  = lx;
        t.tilt_x  = tx;
        t.tilt_y  = ty;
        t.sw      = sw;
        return t;
    endfunction

    function automatic tick_t random_tick();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[48:0];
    endfunction

    function automatic void plan_tick(input tick_t t, input logic typed, input result_t want);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = REG_STARTUP_TICKS;
        row.val    = '0;
        row.t      = t;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input cfg_index_t idx, input logic [7:0] val);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        row.t      = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endfunction

    task automatic send_tick(input tick_t t, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t[47:0];
        s_tuser  <= t.sw;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = interlock_tick(t);
        enable_q.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (enable_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_STARTUP_TICKS:    regs.startup_ticks    = val;
            REG_HOLD_TICKS:       regs.hold_ticks       = val;
            REG_STICK_IDLE_TICKS: regs.stick_idle_ticks = val;
            REG_AWAY_TICKS:       regs.away_ticks       = val;
            REG_TILT_NOISE_BAND:  regs.tilt_noise_band  = val[6:0];
            default: ;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_STARTUP_TICKS, c.startup_ticks);
        write_reg(REG_HOLD_TICKS, c.hold_ticks);
        write_reg(REG_STICK_IDLE_TICKS, c.stick_idle_ticks);
        write_reg(REG_AWAY_TICKS, c.away_ticks);
        // top bit is outside the register and must be ignored
        write_reg(REG_TILT_NOISE_BAND, {1'($urandom_range(0, 1)), c.tilt_noise_band});
    endtask

    // switch held, sticks settle, controller rests tilted with some jitter
    task automatic run_session();
        tick_t base;
        tick_t t;
        int    len;
        int    band;
        int    gap;
        base    = random_tick();
        base.sw = 1'b1;
        if ($urandom_range(0, 9) == 0)
        begin
            base.tilt_x = '0;
            base.tilt_y = '0;
        end
        len = int'(regs.hold_ticks) + int'(regs.stick_idle_ticks) + int'(regs.away_ticks)
              + $urandom_range(0, 12);
        if (len > 220) len = $urandom_range(20, 220);
        for (int k = 0; k < len; k++)
        begin
            if (k < 3 || $urandom_range(0, 49) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: base.right_y = 8'($urandom());
                    1: base.right_x = 8'($urandom());
                    2: base.left_y  = 8'($urandom());
                    default: base.left_x = 8'($urandom());
                endcase
            end
            t = base;
            band = int'(regs.tilt_noise_band);
            if ($urandom_range(0, 3) == 0)
            begin
                t.tilt_x = base.tilt_x + 8'($urandom_range(0, 2 * band + 2)) - 8'(band + 1);
                t.tilt_y = base.tilt_y + 8'($urandom_range(0, 2 * band + 2)) - 8'(band + 1);
            end
            if ($urandom_range(0, 79) == 0) t.sw = 1'b0;
            send_tick(t, 1'b0, '0);
        end
        gap = $urandom_range(1, 3);
        for (int k = 0; k < gap; k++)
        begin
            t    = random_tick();
            t.sw = 1'b0;
            send_tick(t, 1'b0, '0);
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) send_tick(random_tick(), 1'b0, '0);
    endtask

    initial
    begin
        int goal;
        clk           = 1'b0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= REG_STARTUP_TICKS;
        cfg_wdata    <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        m_tready     <= 1'b0;
        errors        = 0;
        ticks_sent    = 0;
        results_seen  = 0;
        reg_writes    = 0;
        shutdowns     = 0;
        drive_ticks   = 0;
        stall_cycles  = 0;
        send_idle_pct = 13;
        recv_idle_pct = 67;
        interlock_reset();

        // inside the startup window everything stays off; a down switch latches
        plan_tick(tk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1, 2'b00);
        plan_tick(tk(8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 1'b0), 1'b1, 2'b00);
        plan_tick(tk(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1), 1'b1, 2'b00);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'hff, 1'b0), 1'b1, 2'b00);
        plan_cfg(REG_STARTUP_TICKS, 8'd0);
        // latched until the switch is released
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'hff, 1'b1), 1'b1, 2'b00);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'hff, 1'b0), 1'b1, 2'b00);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'hff, 1'b1), 1'b1, 2'b01);
        plan_cfg(REG_HOLD_TICKS, 8'd0);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'hff, 1'b1), 1'b1, 2'b11);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h80, 8'h7f, 1'b1), 1'b0, '0);
        // zero away threshold shuts down at once
        plan_cfg(REG_AWAY_TICKS, 8'd0);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h80, 8'h7f, 1'b1), 1'b1, 2'b00);
        plan_tick(tk(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h80, 8'h7f, 1'b0), 1'b1, 2'b00);
        plan_cfg(REG_AWAY_TICKS, 8'd255);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h7f, 1'b0), 1'b1, 2'b01);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h7f, 1'b1), 1'b1, 2'b11);
        plan_cfg(REG_TILT_NOISE_BAND, 8'hff);
        plan_cfg(REG_STICK_IDLE_TICKS, 8'd0);
        // widest noise band: large tilt swings still count as resting
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'hc0, 8'h40, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h7f, 8'h80, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h7f, 1'b1), 1'b0, '0);
        plan_cfg(REG_AWAY_TICKS, 8'd2);
        plan_cfg(REG_TILT_NOISE_BAND, 8'd0);
        // level controller never counts as away; a steady tilt after it does
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h00, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h00, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h10, 8'h00, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h10, 8'h00, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h10, 8'h00, 1'b1), 1'b0, '0);
        plan_tick(tk(8'h01, 8'h02, 8'h03, 8'h04, 8'h10, 8'h00, 1'b0), 1'b0, '0);

        phase_cfg[0] = '{8'd0, 8'd6, 8'd5, 8'd8, 7'd2};
        phase_cfg[1] = '{8'd12, 8'd0, 8'd0, 8'd3, 7'd0};
        phase_cfg[2] = '{8'd12, 8'd255, 8'd255, 8'd255, 7'd127};
        phase_cfg[3] = '{8'd255, 8'd3, 8'd4, 8'd5, 7'd1};
        phase_cfg[5] = '{8'd0, RST_HOLD_TICKS, RST_STICK_IDLE_TICKS, RST_AWAY_TICKS,
                         RST_TILT_NOISE_BAND};
        foreach (phase_cfg[p])
        begin
            if (p == 4 || p > 5)
                phase_cfg[p] = '{8'd0, 8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                                 8'($urandom_range(0, 30)), 7'($urandom_range(0, 10))};
        end
        phase_len = '{200, 160, 120, 260, 160, 200, 160, 160, 160};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_tick(plan[i].t, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            send_idle_pct = (p < 3) ? 13 : (p < 6) ? 67 : 0;
            recv_idle_pct = (p < 3) ? 67 : (p < 6) ? 13 : 0;
            apply_settings(phase_cfg[p]);
            goal = ticks_sent + phase_len[p];
            while (ticks_sent < goal)
            begin
                if ($urandom_range(0, 9) < 7) run_session();
                else run_noise();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("%0d ticks over %0d register writes, %0d results checked",
                 ticks_sent, reg_writes, results_seen);
        $display("drive enabled on %0d ticks, %0d away shutdowns", drive_ticks, shutdowns);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin : enable_check
        result_t want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (enable_q.size() == 0)
            begin
                $error("result transfer with no tick pending: system_enable=%0b drive_enable=%0b",
                       m_tdata[0], m_tdata[1]);
                errors++;
            end
            else
            begin
                want = enable_q.pop_front();
                if (m_tdata[0] !== want.system_enable)
                begin
                    $error("system_enable: expected %0b, got %0b", want.system_enable, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.drive_enable)
                begin
                    $error("drive_enable: expected %0b, got %0b", want.drive_enable, m_tdata[1]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, enable_q.size());
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
